/* rtl/core/pcl_pkg.sv */
`default_nettype none

package pcl_pkg;

  // Fixed field widths
  localparam int unsigned OWNER_W = 16;
  localparam int unsigned PAGE_W  = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CAP_W   = 5;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RANK,
    ST_UPDATE
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic rank;
    logic update;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/pcl_ctrl.sv */
`default_nettype none

module pcl_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  output logic                done_o,
  output pcl_pkg::ctrl_cmd_t  cmd_o
);
  import pcl_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  // State and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Fixed sequence: match, rank pick, update
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_RANK;
      end
      ST_RANK: begin
        cmd_o.rank = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

/* rtl/core/pcl_dpath.sv */
`default_nettype none

module pcl_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  pcl_pkg::ctrl_cmd_t            cmd_i,
  input  wire                           cfg_we_i,
  input  wire [pcl_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  wire                           kind_i,
  input  wire [pcl_pkg::OWNER_W-1:0]    owner_id_i,
  input  wire [pcl_pkg::PAGE_W-1:0]     page_number_i,
  input  wire                           dirty_on_insert_i,
  output logic                          hit_o,
  output logic [pcl_pkg::SLOT_W-1:0]    slot_o,
  output logic                          evicted_o,
  output logic [pcl_pkg::OWNER_W-1:0]   evict_owner_o,
  output logic [pcl_pkg::PAGE_W-1:0]    evict_page_o,
  output logic                          evict_dirty_o
);
  import pcl_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // Request word
  logic               kind_q;
  logic [OWNER_W-1:0] owner_q;
  logic [PAGE_W-1:0]  page_q;
  logic               dirty_q;
  logic [CAP_W-1:0]   cap_q;

  // Entry cells
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dirty_ent_q;
  logic [OWNER_W-1:0] own_q  [ENTRIES];
  logic [PAGE_W-1:0]  pg_q   [ENTRIES];
  logic [IDX_W-1:0]   rank_q [ENTRIES];
  logic [CNT_W-1:0]   count_q;

  // Pipeline between steps
  logic [ENTRIES-1:0] cand_q, cand_d;
  logic               evict_q, evict_d;
  logic [IDX_W-1:0]   target_q, target_d;
  logic               found_q;

  // Result registers
  logic               hit_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               evicted_q;
  logic [OWNER_W-1:0] ev_owner_q;
  logic [PAGE_W-1:0]  ev_page_q;
  logic               wb_q;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      owner_q <= owner_id_i;
      page_q  <= page_number_i;
      dirty_q <= dirty_on_insert_i;
    end
  end

  // Match step: candidate vector for the rank pick
  logic [31:0]        eff_cap;
  logic               full;
  logic [ENTRIES-1:0] tag_eq;
  logic [ENTRIES-1:0] free_oh;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = 32'd1;
    end else if (32'(cap_q) > 32'(ENTRIES)) begin
      eff_cap = 32'(ENTRIES);
    end else begin
      eff_cap = 32'(cap_q);
    end
    full = (count_q != '0) && (32'(count_q) >= eff_cap);
    for (int i = 0; i < ENTRIES; i++) begin
      tag_eq[i] = valid_q[i] && (own_q[i] == owner_q) && (pg_q[i] == page_q);
    end
    // lowest free slot as one-hot
    free_oh = ~valid_q & (valid_q + ENTRIES'(1));
    evict_d = (kind_q == KIND_INSERT) && full;
    priority if (kind_q == KIND_LOOKUP) begin
      cand_d = tag_eq;
    end else if (full) begin
      cand_d = valid_q;
    end else begin
      cand_d = free_oh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      cand_q  <= cand_d;
      evict_q <= evict_d;
    end
  end

  // Rank step: lowest rank among candidates, highest for eviction
  logic [ENTRIES-1:0] rank_hit;
  logic [ENTRIES-1:0] rank_rev;
  logic [ENTRIES-1:0] lo_oh;
  logic [ENTRIES-1:0] hi_oh;
  logic [IDX_W-1:0]   lo_enc;
  logic [IDX_W-1:0]   hi_enc;

  always_comb begin
    rank_hit = '0;
    for (int r = 0; r < ENTRIES; r++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (cand_q[i] && (rank_q[i] == IDX_W'(r))) begin
          rank_hit[r] = 1'b1;
        end
      end
    end
    for (int j = 0; j < ENTRIES; j++) begin
      rank_rev[j] = rank_hit[ENTRIES-1-j];
    end
    lo_oh  = rank_hit & (~rank_hit + ENTRIES'(1));
    hi_oh  = rank_rev & (~rank_rev + ENTRIES'(1));
    lo_enc = '0;
    hi_enc = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (lo_oh[j]) lo_enc = lo_enc | IDX_W'(j);
      if (hi_oh[j]) hi_enc = hi_enc | IDX_W'(j);
    end
    target_d = evict_q ? (IDX_W'(ENTRIES - 1) - hi_enc) : lo_enc;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank) begin
      target_q <= target_d;
      found_q  <= |cand_q;
    end
  end

  // Update step: locate the slot holding the target rank
  logic [ENTRIES-1:0] sel;
  logic [IDX_W-1:0]   slot_idx;
  logic [OWNER_W-1:0] sel_owner;
  logic [PAGE_W-1:0]  sel_page;
  logic               sel_dirty;

  always_comb begin
    slot_idx  = '0;
    sel_owner = '0;
    sel_page  = '0;
    sel_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel[i] = (rank_q[i] == target_q);
      if (sel[i]) begin
        slot_idx  = slot_idx | IDX_W'(i);
        sel_owner = sel_owner | own_q[i];
        sel_page  = sel_page | pg_q[i];
        sel_dirty = sel_dirty | dirty_ent_q[i];
      end
    end
  end

  // Recency, valid, dirty and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_ent_q <= '0;
      count_q     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= IDX_W'(i);
      end
    end else if (cmd_i.update && found_q) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) begin
          rank_q[i] <= '0;
        end else if (rank_q[i] < target_q) begin
          rank_q[i] <= rank_q[i] + IDX_W'(1);
        end
      end
      if (kind_q == KIND_INSERT) begin
        valid_q     <= valid_q | sel;
        dirty_ent_q <= (dirty_ent_q & ~sel) | (dirty_q ? sel : '0);
        if (!evict_q) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
    end
  end

  // Tag cells
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && found_q && (kind_q == KIND_INSERT)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) begin
          own_q[i] <= owner_q;
          pg_q[i]  <= page_q;
        end
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q      <= (kind_q == KIND_LOOKUP) && found_q;
      slot_q     <= found_q ? SLOT_W'(slot_idx) : '0;
      evicted_q  <= evict_q;
      ev_owner_q <= evict_q ? sel_owner : '0;
      ev_page_q  <= evict_q ? sel_page : '0;
      wb_q       <= evict_q && sel_dirty;
    end
  end

  assign hit_o         = hit_q;
  assign slot_o        = slot_q;
  assign evicted_o     = evicted_q;
  assign evict_owner_o = ev_owner_q;
  assign evict_page_o  = ev_page_q;
  assign evict_dirty_o = wb_q;

endmodule

`default_nettype wire

/* rtl/core/page_cache_lru_lookup.sv */
// Page cache tag store, fully associative, least-recently-used replacement.
// Request channel: drive kind_i, owner_id_i, page_number_i and
// dirty_on_insert_i with start_i; the word is taken at a clock edge where
// start_i is high and busy_o is low. kind_i low looks a tag up, high inserts.
// Result channel: done_o is high for exactly one cycle with hit_o, slot_o,
// evicted_o, evict_owner_o, evict_page_o and evict_dirty_o; the receiver
// cannot stall, so it must take the word in that cycle.
// Sequence: the request word is captured at the request edge; the
// controller's fixed sequence then runs tag match, rank pick over the
// recency ranks, then recency update and result register. busy_o drops in
// the same cycle that done_o is high, so a new request is taken only once
// the previous result word is presented.
// Capacity is written through cfg_we_i/cfg_wdata_i; the user must do so
// only while the block is idle, as the block does not enforce it. 0 acts
// as 1 and values above ENTRIES act as ENTRIES. Reset empties the cache
// at once (valid bits cleared, ranks in slot order, capacity 16); there is
// no clearing pass and a request may follow immediately.
`default_nettype none

module page_cache_lru_lookup #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  output logic                          busy_o,
  input  wire                           kind_i,
  input  wire [pcl_pkg::OWNER_W-1:0]    owner_id_i,
  input  wire [pcl_pkg::PAGE_W-1:0]     page_number_i,
  input  wire                           dirty_on_insert_i,
  input  wire                           cfg_we_i,
  input  wire [pcl_pkg::CAP_W-1:0]      cfg_wdata_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [pcl_pkg::SLOT_W-1:0]    slot_o,
  output logic                          evicted_o,
  output logic [pcl_pkg::OWNER_W-1:0]   evict_owner_o,
  output logic [pcl_pkg::PAGE_W-1:0]    evict_page_o,
  output logic                          evict_dirty_o
);
  import pcl_pkg::*;

  ctrl_cmd_t cmd;

  pcl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  pcl_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .kind_i            (kind_i),
    .owner_id_i        (owner_id_i),
    .page_number_i     (page_number_i),
    .dirty_on_insert_i (dirty_on_insert_i),
    .hit_o             (hit_o),
    .slot_o            (slot_o),
    .evicted_o         (evicted_o),
    .evict_owner_o     (evict_owner_o),
    .evict_page_o      (evict_page_o),
    .evict_dirty_o     (evict_dirty_o)
  );

  // Every accepted request yields its result word
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##3 done_o)
    else $error("result word missing four cycles after request");

  // The result cycle is an idle cycle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A lookup hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> !evicted_o)
    else $error("eviction reported on a lookup hit");

  // Without eviction the displaced-entry fields are zero
  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |->
      (evict_owner_o == '0) && (evict_page_o == '0) && !evict_dirty_o)
    else $error("eviction fields set without eviction");

endmodule

`default_nettype wire
